@@ design/gpg_pkg.sv @@
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared constants, types and tables for the gaussian pair generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

    localparam int UNIFORM_BITS  = 32;
    localparam int OUT_FRAC_BITS = 16;
    localparam int OUT_SHIFT     = 28 - OUT_FRAC_BITS;
    localparam int CORDIC_STEPS  = 30;
    localparam int LOG_STEPS     = 30;
    localparam int CW            = 44;

    localparam logic [47:0] SEED_RESET = 48'd20017429951246;
    localparam logic [15:0] DEV_RESET  = 16'd256;
    localparam logic [47:0] LCG_ADD    = 48'hB;

    localparam logic [15:0] LCG_C0  = 16'hE66D;
    localparam logic [15:0] LCG_C1  = 16'hDEEC;
    localparam logic [15:0] LCG_C2  = 16'h0005;
    localparam logic [15:0] LN2_LO  = 16'h2180;
    localparam logic [15:0] LN2_HI  = 16'h0B17;
    localparam logic [15:0] GAIN_LO = 16'h74EE;
    localparam logic [15:0] GAIN_HI = 16'h009B;

    localparam logic [47:0] UMASK = ~((48'd1 << (48 - UNIFORM_BITS)) - 48'd1);
    localparam logic [31:0] PMASK = (UNIFORM_BITS >= 32) ? 32'hFFFF_FFFF :
                                    ~((32'd1 << (32 - UNIFORM_BITS)) - 32'd1);

    localparam logic [7:0] CFG_DEVIATION = 8'd0;
    localparam logic [7:0] CFG_SEED      = 8'd1;

    typedef enum logic [1:0] {
        LANE_0  = 2'd0,
        LANE_16 = 2'd1,
        LANE_32 = 2'd2,
        LANE_48 = 2'd3
    } mac_lane_t;

    typedef struct packed {
        logic      en;
        logic      clear;
        mac_lane_t lane;
    } mac_ctrl_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] turn_atan(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/gpg_mac.sv @@
// ----------------------------------------------------------------------------
// gpg_mac
// Shared 48x16 multiply-accumulate with a 16-bit lane shift.
// ----------------------------------------------------------------------------
module gpg_mac (
    input  logic               clk,
    input  gpg_pkg::mac_ctrl_t ctrl,
    input  logic [47:0]        op_a,
    input  logic [15:0]        op_b,
    output logic [63:0]        acc
);
    import gpg_pkg::*;

    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] prod;
    logic [63:0] shifted;

    assign prod    = {16'd0, op_a} * {48'd0, op_b};
    assign shifted = prod << {ctrl.lane, 4'd0};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.en)
        begin
            acc_next = (ctrl.clear ? 64'd0 : acc_reg) + shifted;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ design/gaussian_pair_generator.sv @@
// ----------------------------------------------------------------------------
// gaussian_pair_generator
// Box-Muller normal pair generator on a 48-bit drand48 style generator.
// ----------------------------------------------------------------------------
// Request channel: request_valid/request_stall carry a tag word. Result
// channel: result_valid/result_stall return the tag and two signed Q15.16
// samples, r*cos and r*sin of one draw.
// One word is worked on at a time; request_stall is high while busy.
// Latency grows with each leading zero of the first uniform and with each
// redraw of a zero uniform; the next request is taken once the block is
// back in idle. The latency is set by the 30 squaring steps of the log
// (each on the shared 48x16 multiplier), the 32 square root digit steps
// and the 30 CORDIC steps.
// A finished word waits in the output register; a new request is taken while
// it waits. A stalled result holds the block in its last step until the
// output register frees up.
// Reset: deviation 1.0, generator reloaded from the reset seed. Writing the
// seed register reloads the generator; write registers only while idle.
// ----------------------------------------------------------------------------
module gaussian_pair_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [7:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               request_valid,
    output logic               request_stall,
    input  logic [7:0]         request_tag,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [7:0]         echo_tag,
    output logic signed [31:0] sample_cos,
    output logic signed [31:0] sample_sin
);
    import gpg_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_LCG   = 15'b000000000000010,
        S_LCGW  = 15'b000000000000100,
        S_NORM  = 15'b000000000001000,
        S_SQR   = 15'b000000000010000,
        S_SQRW  = 15'b000000000100000,
        S_YMUL  = 15'b000000001000000,
        S_ROOTI = 15'b000000010000000,
        S_ROOT  = 15'b000000100000000,
        S_RMUL  = 15'b000001000000000,
        S_RSAVE = 15'b000010000000000,
        S_GMUL  = 15'b000100000000000,
        S_CINIT = 15'b001000000000000,
        S_CORD  = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  sub_reg, sub_next;
    logic [4:0]  iter_reg, iter_next;
    logic [5:0]  k_reg, k_next;
    logic        second_reg, second_next;
    logic [47:0] norm_reg, norm_next;
    logic [31:0] x_reg, x_next;
    logic [29:0] frac_reg, frac_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [47:0] opa_reg, opa_next;
    logic [31:0] phase_reg, phase_next;
    logic [1:0]  quad_reg, quad_next;
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic signed [33:0]   z_reg, z_next;
    logic [7:0]  tag_reg, tag_next;
    logic [47:0] gen_reg, gen_next;
    logic [15:0] dev_reg, dev_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  echo_reg, echo_next;
    logic [31:0] cos_reg, cos_next;
    logic [31:0] sin_reg, sin_next;

    mac_ctrl_t   mac_ctrl;
    logic [47:0] mac_a;
    logic [15:0] mac_b;
    logic [63:0] acc;

    logic [47:0] lcg_new;
    logic [47:0] y_val;
    logic [33:0] sq;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [33:0]   atan_v;
    logic [32:0] qsum;
    logic [1:0]  q_val;
    logic [31:0] z0;
    logic signed [CW-1:0] oc;
    logic signed [CW-1:0] os;
    logic        out_free;

    gpg_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    function automatic logic [31:0] to_output(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        logic signed [CW:0] s;
        logic [31:0]        r;
        t = {v[CW-1], v} + (CW+1)'(1 << (OUT_SHIFT - 1));
        s = t >>> OUT_SHIFT;
        if (s > (CW+1)'(64'sd2147483647))
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (s < -(CW+1)'(64'sd2147483648))
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = s[31:0];
        end
        return r;
    endfunction

    assign lcg_new  = acc[47:0] + LCG_ADD;
    assign y_val    = {6'(UNIFORM_BITS) - k_reg, 30'd0} - {18'd0, frac_reg};
    assign sq       = acc[63:30];
    assign bitv     = 64'd1 << {iter_reg, 1'b0};
    assign trial    = res_reg + bitv;
    assign dx       = cy_reg >>> iter_reg;
    assign dy       = cx_reg >>> iter_reg;
    assign atan_v   = {4'd0, turn_atan(iter_reg)};
    assign qsum     = {1'b0, phase_reg} + 33'h0_2000_0000;
    assign q_val    = qsum[31:30];
    assign z0       = phase_reg - {q_val, 30'd0};
    assign out_free = !ovalid_reg || !result_stall;

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                oc = cx_reg;
                os = cy_reg;
            end
            2'd1:
            begin
                oc = -cy_reg;
                os = cx_reg;
            end
            2'd2:
            begin
                oc = -cx_reg;
                os = -cy_reg;
            end
            default:
            begin
                oc = cy_reg;
                os = -cx_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        sub_next    = sub_reg;
        iter_next   = iter_reg;
        k_next      = k_reg;
        second_next = second_reg;
        norm_next   = norm_reg;
        x_next      = x_reg;
        frac_next   = frac_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        opa_next    = opa_reg;
        phase_next  = phase_reg;
        quad_next   = quad_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        z_next      = z_reg;
        tag_next    = tag_reg;
        gen_next    = gen_reg;
        dev_next    = dev_reg;
        echo_next   = echo_reg;
        cos_next    = cos_reg;
        sin_next    = sin_reg;
        ovalid_next = ovalid_reg && result_stall;
        mac_ctrl    = '{en: 1'b0, clear: 1'b0, lane: LANE_0};
        mac_a       = 48'd0;
        mac_b       = 16'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    tag_next    = request_tag;
                    second_next = 1'b0;
                    sub_next    = 2'd0;
                    state_next  = S_LCG;
                end
            end
            S_LCG:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.clear = (sub_reg == 2'd0);
                mac_a          = gen_reg;
                case (sub_reg)
                    2'd0:
                    begin
                        mac_b         = LCG_C0;
                        mac_ctrl.lane = LANE_0;
                    end
                    2'd1:
                    begin
                        mac_b         = LCG_C1;
                        mac_ctrl.lane = LANE_16;
                    end
                    default:
                    begin
                        mac_b         = LCG_C2;
                        mac_ctrl.lane = LANE_32;
                    end
                endcase
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd2)
                begin
                    state_next = S_LCGW;
                end
            end
            S_LCGW:
            begin
                gen_next   = lcg_new;
                sub_next   = 2'd0;
                state_next = S_LCG;
                if (second_reg)
                begin
                    phase_next = lcg_new[47:16] & PMASK;
                    state_next = S_NORM;
                end
                else if ((lcg_new & UMASK) != 48'd0)
                begin
                    norm_next   = lcg_new & UMASK;
                    k_next      = 6'(UNIFORM_BITS - 1);
                    second_next = 1'b1;
                end
            end
            S_NORM:
            begin
                if (norm_reg[47])
                begin
                    x_next     = {1'b0, norm_reg[47:17]};
                    frac_next  = 30'd0;
                    iter_next  = 5'd0;
                    sub_next   = 2'd0;
                    state_next = S_SQR;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    k_next    = k_reg - 6'd1;
                end
            end
            S_SQR:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = {16'd0, x_reg};
                if (sub_reg == 2'd0)
                begin
                    mac_ctrl.clear = 1'b1;
                    mac_b          = x_reg[15:0];
                    sub_next       = 2'd1;
                end
                else
                begin
                    mac_ctrl.lane = LANE_16;
                    mac_b         = x_reg[31:16];
                    sub_next      = 2'd0;
                    state_next    = S_SQRW;
                end
            end
            S_SQRW:
            begin
                if (sq[31])
                begin
                    frac_next = {frac_reg[28:0], 1'b1};
                    x_next    = sq[32:1];
                end
                else
                begin
                    frac_next = {frac_reg[28:0], 1'b0};
                    x_next    = sq[31:0];
                end
                iter_next  = iter_reg + 5'd1;
                state_next = S_SQR;
                if (iter_reg == 5'(LOG_STEPS - 1))
                begin
                    state_next = S_YMUL;
                end
            end
            S_YMUL:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = y_val;
                if (sub_reg == 2'd0)
                begin
                    mac_ctrl.clear = 1'b1;
                    mac_b          = LN2_LO;
                    sub_next       = 2'd1;
                end
                else
                begin
                    mac_ctrl.lane = LANE_16;
                    mac_b         = LN2_HI;
                    sub_next      = 2'd0;
                    state_next    = S_ROOTI;
                end
            end
            S_ROOTI:
            begin
                rem_next   = {1'b0, acc[63:1]};
                res_next   = 64'd0;
                iter_next  = 5'd31;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bitv;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                iter_next = iter_reg - 5'd1;
                if (iter_reg == 5'd0)
                begin
                    state_next = S_RMUL;
                end
            end
            S_RMUL:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.clear = 1'b1;
                mac_a          = res_reg[47:0];
                mac_b          = dev_reg;
                state_next     = S_RSAVE;
            end
            S_RSAVE:
            begin
                opa_next   = acc[55:8];
                sub_next   = 2'd0;
                state_next = S_GMUL;
            end
            S_GMUL:
            begin
                mac_ctrl.en = 1'b1;
                mac_a       = opa_reg;
                if (sub_reg == 2'd0)
                begin
                    mac_ctrl.clear = 1'b1;
                    mac_b          = GAIN_LO;
                    sub_next       = 2'd1;
                end
                else
                begin
                    mac_ctrl.lane = LANE_16;
                    mac_b         = GAIN_HI;
                    sub_next      = 2'd0;
                    state_next    = S_CINIT;
                end
            end
            S_CINIT:
            begin
                cx_next    = {4'd0, acc[63:24]};
                cy_next    = '0;
                z_next     = {{2{z0[31]}}, z0};
                quad_next  = q_val;
                iter_next  = 5'd0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                if (!z_reg[33])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    z_next  = z_reg - atan_v;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    z_next  = z_reg + atan_v;
                end
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    echo_next   = tag_reg;
                    cos_next    = to_output(oc);
                    sin_next    = to_output(os);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            if (cfg_index == CFG_DEVIATION)
            begin
                dev_next = cfg_data[15:0];
            end
            else if (cfg_index == CFG_SEED)
            begin
                gen_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sub_reg    <= 2'd0;
            iter_reg   <= 5'd0;
            second_reg <= 1'b0;
            gen_reg    <= SEED_RESET;
            dev_reg    <= DEV_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sub_reg    <= sub_next;
            iter_reg   <= iter_next;
            second_reg <= second_next;
            gen_reg    <= gen_next;
            dev_reg    <= dev_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        norm_reg  <= norm_next;
        x_reg     <= x_next;
        frac_reg  <= frac_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        opa_reg   <= opa_next;
        phase_reg <= phase_next;
        quad_reg  <= quad_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        z_reg     <= z_next;
        tag_reg   <= tag_next;
        echo_reg  <= echo_next;
        cos_reg   <= cos_next;
        sin_reg   <= sin_next;
    end

    assign request_stall = (state_reg != S_IDLE);
    assign result_valid  = ovalid_reg;
    assign echo_tag      = echo_reg;
    assign sample_cos    = cos_reg;
    assign sample_sin    = sin_reg;

endmodule
